### hdl/radix2_fft_engine_macros.svh
// Assertion macros for the FFT engine
`ifndef RADIX2_FFT_ENGINE_MACROS_SVH
`define RADIX2_FFT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define R2FFT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define R2FFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define R2FFT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define R2FFT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;

   // transaction kinds
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_RUN  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic RESULT_DONE = 1'b0;
   localparam logic RESULT_BIN  = 1'b1;

   // register indexes
   localparam logic CSR_SIZE_LOG2 = 1'b0;
   localparam logic CSR_INVERSE   = 1'b1;

   localparam int CSR_DATA_W = 4;
   localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         index;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [31:0] bin_re;
      logic signed [31:0] bin_im;
   } rsp_type;

   // one store word
   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } cplx_type;

   // butterfly unit strobes
   typedef struct packed {
      logic cap_a;
      logic mul_en;
      logic t_en;
   } bfly_ctl_type;

   // integer square root, elaboration only
   function automatic longint unsigned isqrt64(longint unsigned v_in);
      longint unsigned v;
      longint unsigned r;
      longint unsigned b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // shift-subtract unsigned quotient, elaboration only
   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      q = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 1) | ((num >> i) & 64'd1);
         if (rem >= den) begin
            rem = rem - den;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   // twiddle entry idx of a table of 2^(max_log2-1), Q1.(tw_bits-2)
   function automatic longint twiddle_value(int max_log2, int tw_bits, int idx, bit imag);
      longint step_c [0:16];
      longint step_s [0:16];
      longint unsigned c;
      longint unsigned s;
      longint a;
      longint b;
      longint na;
      longint nb;
      int rom_log;
      step_c[0] = 0;
      step_s[0] = 0;
      step_c[1] = 0;
      step_s[1] = longint'(1) << 30;
      for (int k = 2; k <= 16; k++) begin
         step_c[k] = 0;
         step_s[k] = 0;
      end
      for (int k = 2; k <= max_log2; k++) begin
         c = isqrt64(longint'((longint'(1) << 30) + step_c[k-1]) << 29);
         s = udiv64((longint'(step_s[k-1]) << 29) + (c >> 1), c);
         step_c[k] = longint'(c);
         step_s[k] = longint'(s);
      end
      rom_log = max_log2 - 1;
      a = longint'(1) << 30;
      b = 0;
      // apply the rotation steps from the coarsest to the finest
      for (int p = 15; p >= 0; p--) begin
         if (p < rom_log && ((idx >> p) & 1) == 1) begin
            na = round_shift(a * step_c[rom_log - p] + b * step_s[rom_log - p], 30);
            nb = round_shift(b * step_c[rom_log - p] - a * step_s[rom_log - p], 30);
            a = na;
            b = nb;
         end
      end
      return round_shift(imag ? b : a, 30 - (tw_bits - 2));
   endfunction

endpackage

### hdl/r2fft_ram.sv
`timescale 1ns / 1ps
module r2fft_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/r2fft_twiddle_rom.sv
`timescale 1ns / 1ps
module r2fft_twiddle_rom #(
   parameter int MAX_LOG2     = 10,
   parameter int TWIDDLE_BITS = 18,
   parameter int ROM_W        = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [ROM_W-1:0]               rd_addr,
   output logic signed [TWIDDLE_BITS-1:0] tw_re,
   output logic signed [TWIDDLE_BITS-1:0] tw_im
);

   localparam int ROM_LEN = 1 << ROM_W;

   logic signed [TWIDDLE_BITS-1:0] rom_re [ROM_LEN];
   logic signed [TWIDDLE_BITS-1:0] rom_im [ROM_LEN];
   logic signed [TWIDDLE_BITS-1:0] tw_re_ff;
   logic signed [TWIDDLE_BITS-1:0] tw_im_ff;

   // constant table, built at elaboration
   for (genvar g = 0; g < ROM_LEN; g++) begin : g_rom
      localparam logic signed [TWIDDLE_BITS-1:0] ENT_RE =
         TWIDDLE_BITS'(r2fft_pkg::twiddle_value(MAX_LOG2, TWIDDLE_BITS, g, 1'b0));
      localparam logic signed [TWIDDLE_BITS-1:0] ENT_IM =
         TWIDDLE_BITS'(r2fft_pkg::twiddle_value(MAX_LOG2, TWIDDLE_BITS, g, 1'b1));
      assign rom_re[g] = ENT_RE;
      assign rom_im[g] = ENT_IM;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tw_re_ff <= rom_re[rd_addr];
         tw_im_ff <= rom_im[rd_addr];
      end
   end

   assign tw_re = tw_re_ff;
   assign tw_im = tw_im_ff;

endmodule

### hdl/r2fft_bfly.sv
`timescale 1ns / 1ps
module r2fft_bfly #(
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                           clock,
   input  r2fft_pkg::bfly_ctl_type        ctl,
   input  logic                           inverse,
   input  r2fft_pkg::cplx_type            rd_word,
   input  logic signed [TWIDDLE_BITS-1:0] tw_re,
   input  logic signed [TWIDDLE_BITS-1:0] tw_im,
   output r2fft_pkg::cplx_type            a_word,
   output r2fft_pkg::cplx_type            sum_word,
   output r2fft_pkg::cplx_type            diff_word
);

   localparam int TF = TWIDDLE_BITS - 2;
   localparam int PW = 32 + TWIDDLE_BITS + 1;

   r2fft_pkg::cplx_type a_ff;
   logic signed [TWIDDLE_BITS:0] wr;
   logic signed [TWIDDLE_BITS:0] wi;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PW:0]   acc_re, acc_im;
   logic signed [PW:0]   rnd_re, rnd_im;
   logic signed [31:0]   t_re_ff, t_im_ff;
   logic signed [32:0]   s_re, s_im, d_re, d_im;

   function automatic logic signed [31:0] sat_wide(logic signed [PW:0] v);
      if ((&v[PW:31]) || !(|v[PW:31])) return v[31:0];
      return v[PW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   function automatic logic signed [31:0] sat33(logic signed [32:0] v);
      if (v[32] == v[31]) return v[31:0];
      return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   // conjugate twiddle for inverse
   assign wr = {tw_re[TWIDDLE_BITS-1], tw_re};
   assign wi = inverse ? -{tw_im[TWIDDLE_BITS-1], tw_im} : {tw_im[TWIDDLE_BITS-1], tw_im};

   // A capture, products stage and rounded T register
   always_ff @(posedge clock) begin
      if (ctl.cap_a) a_ff <= rd_word;
      if (ctl.mul_en) begin
         p_rr_ff <= PW'(rd_word.re * wr);
         p_ii_ff <= PW'(rd_word.im * wi);
         p_ri_ff <= PW'(rd_word.re * wi);
         p_ir_ff <= PW'(rd_word.im * wr);
      end
      if (ctl.t_en) begin
         t_re_ff <= sat_wide(rnd_re);
         t_im_ff <= sat_wide(rnd_im);
      end
   end

   // combine, round half up, drop fraction
   always_comb begin
      acc_re = (PW+1)'(p_rr_ff) - (PW+1)'(p_ii_ff);
      acc_im = (PW+1)'(p_ri_ff) + (PW+1)'(p_ir_ff);
      rnd_re = (acc_re + ((PW+1)'(1) <<< (TF - 1))) >>> TF;
      rnd_im = (acc_im + ((PW+1)'(1) <<< (TF - 1))) >>> TF;
   end

   // saturating add and subtract
   always_comb begin
      s_re = 33'(a_ff.re) + 33'(t_re_ff);
      s_im = 33'(a_ff.im) + 33'(t_im_ff);
      d_re = 33'(a_ff.re) - 33'(t_re_ff);
      d_im = 33'(a_ff.im) - 33'(t_im_ff);
      sum_word.re  = sat33(s_re);
      sum_word.im  = sat33(s_im);
      diff_word.re = sat33(d_re);
      diff_word.im = sat33(d_im);
   end

   assign a_word = a_ff;

endmodule

### hdl/radix2_fft_engine.sv
// In-place radix-2 decimation-in-time FFT over N = 2^t complex points, t = size_log2
// clamped to 1..MAX_LOG2, held in a single-port-read, single-port-write sample store.
// A load transaction writes the store as it is accepted; a read transaction's bin
// passes the store's read register, then the response register. A run transaction
// reorders the store, then performs N/2 * log2(N) butterflies, then in inverse mode
// rescales the store by 1/N, and answers with a done item; the store's one read and
// one write per cycle pace these passes. No transaction is accepted until the current
// one has finished. Reading a bin that was never loaded returns undefined data.
`timescale 1ns / 1ps
`include "radix2_fft_engine_macros.svh"
module radix2_fft_engine #(
   parameter int MAX_LOG2     = 10,
   parameter int SAMPLE_BITS  = 16,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  r2fft_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output r2fft_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [r2fft_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W = MAX_LOG2;
   localparam int CNT_W  = MAX_LOG2 + 1;
   localparam int T_W    = $clog2(MAX_LOG2 + 1);
   localparam int ROM_W  = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_RD_OUT = 16'h0002,
      ST_BR_RI  = 16'h0004,
      ST_BR_RJ  = 16'h0008,
      ST_BR_WI  = 16'h0010,
      ST_BR_WJ  = 16'h0020,
      ST_BF_RA  = 16'h0040,
      ST_BF_RB  = 16'h0080,
      ST_BF_MUL = 16'h0100,
      ST_BF_T   = 16'h0200,
      ST_BF_WA  = 16'h0400,
      ST_BF_WB  = 16'h0800,
      ST_SC_RD  = 16'h1000,
      ST_SC_WR  = 16'h2000,
      ST_DONE   = 16'h4000,
      ST_SPARE  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]       size_log2_ff;
   logic             inverse_ff;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] m_ff, m_in;
   logic [T_W-1:0]   s_ff, s_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   r2fft_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [4:0]       sz5;
   logic [T_W-1:0]   t;
   logic [CNT_W-1:0] n, h, j;
   logic [ADDR_W-1:0] i_a, rev;
   logic             req_fire, idx_ok, rsp_free;
   logic [SAMPLE_BITS-1:0] smp_re, smp_im;

   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   r2fft_pkg::cplx_type mem_wdata, mem_rdata;
   logic                tw_rd;
   logic [ROM_W-1:0]    tw_addr;
   logic signed [TWIDDLE_BITS-1:0] tw_re, tw_im;
   r2fft_pkg::bfly_ctl_type bctl;
   r2fft_pkg::cplx_type a_word, sum_word, diff_word;

   // effective size clamp
   assign sz5 = {1'b0, size_log2_ff};
   always_comb begin
      if (sz5 == 5'd0) t = T_W'(1);
      else if (sz5 > 5'(MAX_LOG2)) t = T_W'(MAX_LOG2);
      else t = T_W'(sz5);
   end
   assign n = CNT_W'(1) << t;
   assign h = CNT_W'(1) << s_ff;

   // bit-reversed partner of i
   assign i_a = i_ff[ADDR_W-1:0];
   always_comb begin
      for (int b = 0; b < ADDR_W; b++) rev[b] = i_a[ADDR_W-1-b];
   end
   assign j = CNT_W'(rev >> (T_W'(MAX_LOG2) - t));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign idx_ok    = ((req_data.index >> t) == 10'd0);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign smp_re    = SAMPLE_BITS'(unsigned'(req_data.sample_re));
   assign smp_im    = SAMPLE_BITS'(unsigned'(req_data.sample_im));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= r2fft_pkg::SIZE_LOG2_RESET;
         inverse_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            r2fft_pkg::CSR_SIZE_LOG2: size_log2_ff <= csr_wdata[3:0];
            r2fft_pkg::CSR_INVERSE:   inverse_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      s_in         = s_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = i_a;
      mem_wdata    = mem_rdata;
      mem_re       = 1'b0;
      mem_raddr    = i_a;
      tw_rd        = 1'b0;
      tw_addr      = ROM_W'(k_ff << (T_W'(MAX_LOG2 - 1) - s_ff));
      bctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.kind)
                  r2fft_pkg::KIND_LOAD: begin
                     mem_we       = idx_ok;
                     mem_waddr    = ADDR_W'(req_data.index);
                     mem_wdata.re = 32'(signed'(smp_re));
                     mem_wdata.im = 32'(signed'(smp_im));
                  end
                  r2fft_pkg::KIND_RUN: begin
                     i_in     = '0;
                     state_in = ST_BR_RI;
                  end
                  r2fft_pkg::KIND_READ: begin
                     mem_re    = idx_ok;
                     mem_raddr = ADDR_W'(req_data.index);
                     rd_ok_in  = idx_ok;
                     state_in  = ST_RD_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_OUT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = r2fft_pkg::RESULT_BIN;
               rsp_data_in.bin_re      = rd_ok_ff ? mem_rdata.re : '0;
               rsp_data_in.bin_im      = rd_ok_ff ? mem_rdata.im : '0;
               state_in                = ST_IDLE;
            end
         end
         // bit-reversal reorder
         ST_BR_RI: begin
            if (i_ff == n) begin
               s_in     = '0;
               k_in     = '0;
               m_in     = '0;
               state_in = ST_BF_RA;
            end else if (i_ff < j) begin
               mem_re   = 1'b1;
               state_in = ST_BR_RJ;
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ST_BR_RJ: begin
            mem_re     = 1'b1;
            mem_raddr  = ADDR_W'(j);
            bctl.cap_a = 1'b1;
            state_in   = ST_BR_WI;
         end
         // x[i] is held in the butterfly's A register
         ST_BR_WI: begin
            mem_we     = 1'b1;
            state_in   = ST_BR_WJ;
         end
         ST_BR_WJ: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(j);
            mem_wdata = a_word;
            i_in      = i_ff + CNT_W'(1);
            state_in  = ST_BR_RI;
         end
         // butterflies
         ST_BF_RA: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(m_ff);
            tw_rd     = 1'b1;
            state_in  = ST_BF_RB;
         end
         ST_BF_RB: begin
            mem_re     = 1'b1;
            mem_raddr  = ADDR_W'(m_ff + h);
            bctl.cap_a = 1'b1;
            state_in   = ST_BF_MUL;
         end
         ST_BF_MUL: begin
            bctl.mul_en = 1'b1;
            state_in    = ST_BF_T;
         end
         ST_BF_T: begin
            bctl.t_en = 1'b1;
            state_in  = ST_BF_WA;
         end
         ST_BF_WA: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(m_ff);
            mem_wdata = sum_word;
            state_in  = ST_BF_WB;
         end
         ST_BF_WB: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(m_ff + h);
            mem_wdata = diff_word;
            state_in  = ST_BF_RA;
            if (m_ff + (h << 1) < n - h) begin
               m_in = m_ff + (h << 1);
            end else if (k_ff + CNT_W'(1) < h) begin
               k_in = k_ff + CNT_W'(1);
               m_in = k_ff + CNT_W'(1);
            end else if ((h << 1) < n) begin
               s_in = s_ff + T_W'(1);
               k_in = '0;
               m_in = '0;
            end else begin
               i_in     = '0;
               state_in = inverse_ff ? ST_SC_RD : ST_DONE;
            end
         end
         // inverse scaling
         ST_SC_RD: begin
            if (i_ff == n) begin
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_SC_WR;
            end
         end
         ST_SC_WR: begin
            mem_we       = 1'b1;
            mem_wdata.re = mem_rdata.re >>> t;
            mem_wdata.im = mem_rdata.im >>> t;
            i_in         = i_ff + CNT_W'(1);
            state_in     = ST_SC_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = r2fft_pkg::RESULT_DONE;
               rsp_data_in.bin_re      = '0;
               rsp_data_in.bin_im      = '0;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      s_ff        <= s_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   r2fft_ram #(
      .WIDTH ($bits(r2fft_pkg::cplx_type)),
      .DEPTH (1 << MAX_LOG2)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   r2fft_twiddle_rom #(
      .MAX_LOG2     (MAX_LOG2),
      .TWIDDLE_BITS (TWIDDLE_BITS),
      .ROM_W        (ROM_W)
   ) u_twiddle (
      .clock   (clock),
      .rd_en   (tw_rd),
      .rd_addr (tw_addr),
      .tw_re   (tw_re),
      .tw_im   (tw_im)
   );

   r2fft_bfly #(
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_bfly (
      .clock     (clock),
      .ctl       (bctl),
      .inverse   (inverse_ff),
      .rd_word   (mem_rdata),
      .tw_re     (tw_re),
      .tw_im     (tw_im),
      .a_word    (a_word),
      .sum_word  (sum_word),
      .diff_word (diff_word)
   );

   // a run transaction starts the reorder pass
   `R2FFT_ASSERT_NEXT(a_run_start, clock, reset, req_fire && req_data.kind == r2fft_pkg::KIND_RUN, state_ff == ST_BR_RI)
   // store writes stay inside the active size
   `R2FFT_ASSERT_IMPL(a_wr_in_size, clock, reset, mem_we, (CNT_W'(mem_waddr) < n))
   // a result only appears from the read or done step
   `R2FFT_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_RD_OUT || $past(state_ff) == ST_DONE)

endmodule
